[hw/rtl/lpsfw_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the LED PWM shift frame writer.
// No dependencies; every other file of the block imports this package.
package lpsfw_pkg;

   localparam int DEF_MAX_DRIVERS     = 12;
   localparam int CHANNELS_PER_DRIVER = 24;
   localparam int LEVEL_BITS          = 12;
   localparam int CHANNEL_BITS        = 9;
   localparam int VALUE_BITS          = 16;
   localparam int OP_BITS             = 2;
   localparam int NUM_DRV_BITS        = 4;
   localparam int BIT_SEL_BITS        = 4;
   localparam int PHASE_BITS          = 3;

   localparam logic [NUM_DRV_BITS-1:0] NUM_DRV_RESET = 4'd12;
   localparam logic [LEVEL_BITS-1:0]   LEVEL_MAX     = 12'hFFF;
   localparam logic [BIT_SEL_BITS-1:0] BIT_TOP       = 4'd11;

   // request operation codes
   localparam logic [OP_BITS-1:0] OP_SET   = 2'd0;
   localparam logic [OP_BITS-1:0] OP_START = 2'd1;
   localparam logic [OP_BITS-1:0] OP_TICK  = 2'd2;

   // frame sequencer state codes
   localparam logic [PHASE_BITS-1:0] PH_IDLE     = 3'd0;
   localparam logic [PHASE_BITS-1:0] PH_BIT_LOW  = 3'd1;
   localparam logic [PHASE_BITS-1:0] PH_BIT_HIGH = 3'd2;
   localparam logic [PHASE_BITS-1:0] PH_END_CLK  = 3'd3;
   localparam logic [PHASE_BITS-1:0] PH_LAT_HIGH = 3'd4;
   localparam logic [PHASE_BITS-1:0] PH_LAT_LOW  = 3'd5;

   // result item, shift_clock in bit 0
   typedef struct packed {
      logic accepted;
      logic busy_res;
      logic latch;
      logic shift_data;
      logic shift_clock;
   } rsp_type;

   localparam int RSP_BITS = $bits(rsp_type);

   // sequencer status seen by the top level
   typedef struct packed {
      logic [PHASE_BITS-1:0] phase;
      logic                  latch;
      logic                  store_write;
   } frame_stat_type;

endpackage

[hw/rtl/lpsfw_level_store.sv]
`timescale 1ns / 1ps
// Grey-scale level memory: one write port, one registered read port,
// and a zero-fill pass after reset. Depends on lpsfw_pkg.
module lpsfw_level_store
   import lpsfw_pkg::*;
#(
   parameter int MAX_DRIVERS = DEF_MAX_DRIVERS,
   localparam int DEPTH  = MAX_DRIVERS * CHANNELS_PER_DRIVER,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  logic [LEVEL_BITS-1:0] wr_data,
   input  logic [ADDR_W-1:0]     rd_addr,
   output logic [LEVEL_BITS-1:0] rd_data,
   output logic                  clearing
);

   logic [LEVEL_BITS-1:0] mem [DEPTH];
   logic [LEVEL_BITS-1:0] rd_data_ff;
   logic [ADDR_W-1:0]     clr_cnt_ff, clr_cnt_in;
   logic                  clearing_ff, clearing_in;

   always_comb begin
      clr_cnt_in  = clr_cnt_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         if (clr_cnt_ff == ADDR_W'(DEPTH - 1)) begin
            clearing_in = 1'b0;
         end else begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff  <= '0;
         clearing_ff <= 1'b1;
      end else begin
         clr_cnt_ff  <= clr_cnt_in;
         clearing_ff <= clearing_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_cnt_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clearing_ff;

endmodule

[hw/rtl/lpsfw_frame_ctrl.sv]
`timescale 1ns / 1ps
// Frame sequencer: decodes each request, updates pins and counters,
// and forms the result item. Depends on lpsfw_pkg.
module lpsfw_frame_ctrl
   import lpsfw_pkg::*;
#(
   parameter int MAX_DRIVERS = DEF_MAX_DRIVERS,
   localparam int DEPTH  = MAX_DRIVERS * CHANNELS_PER_DRIVER,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    take,
   input  logic [OP_BITS-1:0]      req_operation,
   input  logic [CHANNEL_BITS-1:0] req_channel,
   input  logic [VALUE_BITS-1:0]   req_value,
   input  logic [NUM_DRV_BITS-1:0] num_drivers,
   input  logic [LEVEL_BITS-1:0]   rd_data,
   output logic [ADDR_W-1:0]       rd_addr,
   output logic                    wr_en,
   output logic [ADDR_W-1:0]       wr_addr,
   output logic [LEVEL_BITS-1:0]   wr_data,
   output rsp_type                 rsp,
   output frame_stat_type          stat
);

   logic [PHASE_BITS-1:0]   phase_ff, phase_in;
   logic [ADDR_W-1:0]       chan_ff, chan_in;
   logic [BIT_SEL_BITS-1:0] bit_ff, bit_in;
   logic                    clk_ff, clk_in;
   logic                    dat_ff, dat_in;
   logic                    lat_ff, lat_in;
   logic                    busy, ok;
   logic [NUM_DRV_BITS:0]   drv_eff;
   logic [CHANNEL_BITS-1:0] active;

   // driver counts past the store size act as the store size
   always_comb begin
      if ({1'b0, num_drivers} > (NUM_DRV_BITS + 1)'(MAX_DRIVERS)) begin
         drv_eff = (NUM_DRV_BITS + 1)'(MAX_DRIVERS);
      end else begin
         drv_eff = {1'b0, num_drivers};
      end
      active = CHANNEL_BITS'(drv_eff) * CHANNEL_BITS'(CHANNELS_PER_DRIVER);
   end

   assign busy    = (phase_ff != PH_IDLE);
   assign wr_addr = ADDR_W'(req_channel);
   assign wr_data = (|req_value[VALUE_BITS-1:LEVEL_BITS]) ? LEVEL_MAX
                                                          : req_value[LEVEL_BITS-1:0];

   always_comb begin
      phase_in = phase_ff;
      chan_in  = chan_ff;
      bit_in   = bit_ff;
      clk_in   = clk_ff;
      dat_in   = dat_ff;
      lat_in   = lat_ff;
      ok       = 1'b0;
      wr_en    = 1'b0;
      if (take) begin
         unique case (req_operation)
            OP_SET: begin
               if (!busy && (req_channel < active)) begin
                  wr_en = 1'b1;
                  ok    = 1'b1;
               end
            end
            OP_START: begin
               if (!busy) begin
                  ok     = 1'b1;
                  dat_in = 1'b0;
                  bit_in = BIT_TOP;
                  if (active == '0) begin
                     chan_in  = '0;
                     phase_in = PH_END_CLK;
                  end else begin
                     chan_in  = ADDR_W'(active - 1'b1);
                     phase_in = PH_BIT_LOW;
                  end
               end
            end
            OP_TICK: begin
               if (busy) begin
                  ok = 1'b1;
                  unique case (phase_ff)
                     PH_BIT_LOW: begin
                        clk_in   = 1'b0;
                        dat_in   = rd_data[bit_ff];
                        phase_in = PH_BIT_HIGH;
                     end
                     PH_BIT_HIGH: begin
                        clk_in = 1'b1;
                        if (bit_ff != '0) begin
                           bit_in   = bit_ff - 1'b1;
                           phase_in = PH_BIT_LOW;
                        end else if (chan_ff != '0) begin
                           chan_in  = chan_ff - 1'b1;
                           bit_in   = BIT_TOP;
                           phase_in = PH_BIT_LOW;
                        end else begin
                           bit_in   = BIT_TOP;
                           phase_in = PH_END_CLK;
                        end
                     end
                     PH_END_CLK: begin
                        clk_in   = 1'b0;
                        phase_in = PH_LAT_HIGH;
                     end
                     PH_LAT_HIGH: begin
                        lat_in   = 1'b1;
                        phase_in = PH_LAT_LOW;
                     end
                     default: begin
                        lat_in   = 1'b0;
                        phase_in = PH_IDLE;
                     end
                  endcase
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         chan_ff  <= '0;
         bit_ff   <= BIT_TOP;
         clk_ff   <= 1'b0;
         dat_ff   <= 1'b0;
         lat_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         chan_ff  <= chan_in;
         bit_ff   <= bit_in;
         clk_ff   <= clk_in;
         dat_ff   <= dat_in;
         lat_ff   <= lat_in;
      end
   end

   // prefetch the level of the channel that the next low tick will send
   assign rd_addr = chan_in;

   always_comb begin
      rsp.shift_clock = clk_in;
      rsp.shift_data  = dat_in;
      rsp.latch       = lat_in;
      rsp.busy_res    = (phase_in != PH_IDLE);
      rsp.accepted    = ok;
   end

   always_comb begin
      stat.phase       = phase_ff;
      stat.latch       = lat_ff;
      stat.store_write = wr_en;
   end

endmodule

[hw/rtl/lpsfw_rsp_buf.sv]
`timescale 1ns / 1ps
// Result register with a skid stage, so a request is taken while a
// result waits. Depends on lpsfw_pkg.
module lpsfw_rsp_buf
   import lpsfw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  rsp_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   rsp_type out_data_ff, out_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;

   always_comb begin
      out_data_in   = out_data_ff;
      out_valid_in  = out_valid_ff;
      skid_data_in  = skid_data_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (out_ready) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_valid_ff || out_ready) begin
            out_data_in  = in_data;
            out_valid_in = 1'b1;
         end else begin
            // hold the new result behind the stalled one
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

[hw/rtl/led_pwm_shift_frame_writer.sv]
`timescale 1ns / 1ps
// Top level of the LED PWM shift frame writer: level store, frame
// sequencer and result buffer. Depends on lpsfw_pkg and the lpsfw_* modules.
//
//   channel  direction  handshake            payload
//   req      in         req_tvalid/tready    tuser operation, tdata channel, value
//   rsp      out        rsp_tvalid/tready    tdata pin levels, busy, accepted
//   csr      in         csr_valid/ready      csr_data num_drivers
//
// One request per cycle while req_tready is high; each result is registered.
// After reset all MAX_DRIVERS*24 level store entries (288 by default) are
// zero-filled and no request is taken meanwhile; csr writes still are.
// The skid stage takes one more request while a result stalls, then holds
// req_tready low until rsp_tready frees it.
module led_pwm_shift_frame_writer
   import lpsfw_pkg::*;
#(
   parameter int MAX_DRIVERS = DEF_MAX_DRIVERS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [OP_BITS-1:0]      req_tuser,   // operation
   input  logic [31:0]             req_tdata,   // channel[8:0], value[24:9], zeros
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              rsp_tdata,   // shift_clock, shift_data, latch,
                                                // busy_res, accepted, zeros
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [NUM_DRV_BITS-1:0] csr_data     // num_drivers
);

   localparam int DEPTH  = MAX_DRIVERS * CHANNELS_PER_DRIVER;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [NUM_DRV_BITS-1:0] num_drivers_ff, num_drivers_in;
   logic                    take, buf_ready, clearing;
   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr, rd_addr;
   logic [LEVEL_BITS-1:0]   wr_data, rd_data;
   rsp_type                 rsp_next, rsp_out;
   frame_stat_type          stat;

   assign csr_ready      = 1'b1;
   assign num_drivers_in = (csr_valid && csr_ready) ? csr_data : num_drivers_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_drivers_ff <= NUM_DRV_RESET;
      end else begin
         num_drivers_ff <= num_drivers_in;
      end
   end

   assign req_tready = buf_ready && !clearing;
   assign take       = req_tvalid && req_tready;

   lpsfw_level_store #(.MAX_DRIVERS(MAX_DRIVERS)) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .clearing (clearing)
   );

   lpsfw_frame_ctrl #(.MAX_DRIVERS(MAX_DRIVERS)) u_frame (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .req_operation (req_tuser),
      .req_channel   (req_tdata[CHANNEL_BITS-1:0]),
      .req_value     (req_tdata[CHANNEL_BITS +: VALUE_BITS]),
      .num_drivers   (num_drivers_ff),
      .rd_data       (rd_data),
      .rd_addr       (rd_addr),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rsp           (rsp_next),
      .stat          (stat)
   );

   lpsfw_rsp_buf u_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (take),
      .in_ready  (buf_ready),
      .in_data   (rsp_next),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_out)
   );

   assign rsp_tdata = {(8 - RSP_BITS)'(0), rsp_out};

   // the store never changes while a frame is on the wire
   a_no_write_in_frame: assert property (@(posedge clock) disable iff (reset)
      (stat.phase != PH_IDLE) |-> !stat.store_write)
      else $error("level store written during a frame");

   // latch is high only between its rising and falling ticks
   a_latch_phase: assert property (@(posedge clock) disable iff (reset)
      stat.latch |-> (stat.phase == PH_LAT_LOW))
      else $error("latch high outside the latch pulse");

   // every taken request yields a pending result
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_tvalid)
      else $error("request taken without a result");

   // back-pressure after the fill pass only comes from a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      (!req_tready && !clearing) |-> rsp_tvalid)
      else $error("request stalled with no result pending");

endmodule
